[src/gigapage_io_map_allocator_assert.svh]
// ---------------------------------------------------------------------------
// gigapage io map allocator assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef GIGAPAGE_IO_MAP_ALLOCATOR_ASSERT_SVH
`define GIGAPAGE_IO_MAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GMAP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("gmap assertion failed");
// next-cycle implication
`define GMAP_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("gmap assertion failed");
`else
`define GMAP_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define GMAP_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

[src/gmap_pkg.sv]
// ---------------------------------------------------------------------------
// gmap package
// request and result types, opcodes, status codes and entry bits
// ---------------------------------------------------------------------------
package gmap_pkg;
	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_UNMAP = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ZERO_LEN   = 3'd1;
	localparam logic [2:0] ST_TOO_MANY   = 3'd2;
	localparam logic [2:0] ST_NO_RUN     = 3'd3;
	localparam logic [2:0] ST_BAD_UNMAP  = 3'd4;

	localparam int unsigned ENTRY_VALID_BIT = 0;
	localparam int unsigned ENTRY_LAST_BIT  = 8;
	localparam logic [63:0] TOP_BASE = 64'hFFFF_FF80_0000_0000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [55:0] phys_addr;
		logic [38:0] region_length;
		logic [63:0] attributes;
		logic [63:0] unmap_addr;
		logic [8:0]  entry_index;
		logic [63:0] entry_value;
	} in_req_t;

	typedef struct packed {
		logic [63:0] result_addr;
		logic [2:0]  status;
		logic [8:0]  first_entry;
		logic [8:0]  last_entry;
	} res_t;
endpackage

[src/gmap_mem.sv]
// ---------------------------------------------------------------------------
// gmap table memory
// single write port, single registered read port, no reset on contents
// ---------------------------------------------------------------------------
module gmap_mem #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/gmap_ctrl.sv]
// ---------------------------------------------------------------------------
// gmap controller
// clearing pass, run search, entry fill and unmap walk over the table
// ---------------------------------------------------------------------------
`include "gigapage_io_map_allocator_assert.svh"
module gmap_ctrl #(
	parameter int unsigned TABLE_ENTRIES = 512,
	parameter int unsigned PAGE_SHIFT    = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             paging_enabled,
	input  logic             in_valid,
	output logic             in_ready,
	input  gmap_pkg::in_req_t in_req,
	input  logic             res_room,
	output logic             res_valid,
	output gmap_pkg::res_t   res
);
	import gmap_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = IW + 1;
	localparam int unsigned BW = IW + 2;
	localparam logic [41:0] PAGE_M1   = (42'd1 << PAGE_SHIFT) - 42'd1;
	localparam logic [55:0] PMASK     = (56'd1 << PAGE_SHIFT) - 56'd1;
	localparam logic [57:0] PAGE_INC  = 58'd1 << PAGE_SHIFT;
	localparam logic [63:0] OFF_MASK  = (64'd1 << PAGE_SHIFT) - 64'd1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PREP, S_STRIDE, S_SCAN, S_SRD, S_SCHK, S_WR,
		S_URD, S_UCHK, S_DONE
	} state_t;

	state_t      state_q;
	logic [BW-1:0] idx_q, base_q, end_q;
	logic [CW-1:0] cnt_q, stride_q;
	logic [57:0] pa_q;
	logic [63:0] off_q;
	logic [38:0] len_q;
	logic [63:0] attr_q;
	logic [BW-1:0] first_q;
	res_t        res_q;

	logic          mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [63:0]   mem_wdata, mem_rdata;
	logic [41:0]   sum_w, cnt_w;
	logic [63:0]   udiff, uslot;
	logic          last_wr;
	logic          accept;

	// whole result word in one go
	function automatic res_t pack_res(logic [63:0] addr, logic [2:0] st,
			logic [8:0] first_slot, logic [8:0] last_slot);
		res_t r;
		r.result_addr = addr;
		r.status      = st;
		r.first_entry = first_slot;
		r.last_entry  = last_slot;
		return r;
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE) && res_room;
	assign res       = res_q;

	assign sum_w   = 42'(off_q) + 42'(len_q) + PAGE_M1;
	assign cnt_w   = sum_w >> PAGE_SHIFT;
	assign udiff   = in_req.unmap_addr - TOP_BASE;
	assign uslot   = udiff >> PAGE_SHIFT;
	assign last_wr = ((idx_q + BW'(1)) == end_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IW-1:0];
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = idx_q[IW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (accept && in_req.opcode == OP_LOAD
						&& 32'(in_req.entry_index) < TABLE_ENTRIES) begin
					mem_we    = 1'b1;
					mem_waddr = IW'(in_req.entry_index);
					mem_wdata = in_req.entry_value;
				end
			end
			S_SRD, S_URD: begin
				mem_re = 1'b1;
			end
			S_WR: begin
				mem_we    = 1'b1;
				mem_wdata = 64'(pa_q >> 2) | attr_q;
				mem_wdata[ENTRY_LAST_BIT] = mem_wdata[ENTRY_LAST_BIT] | last_wr;
			end
			S_UCHK: begin
				// clear only a valid entry
				mem_we = mem_rdata[ENTRY_VALID_BIT];
			end
			default: begin
			end
		endcase
	end

	gmap_mem #(.DEPTH(TABLE_ENTRIES), .AW(IW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			idx_q    <= '0;
			base_q   <= '0;
			end_q    <= '0;
			cnt_q    <= '0;
			stride_q <= '0;
			pa_q     <= '0;
			off_q    <= '0;
			len_q    <= '0;
			attr_q   <= '0;
			first_q  <= '0;
			res_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (32'(idx_q) == TABLE_ENTRIES - 1) begin
						state_q <= S_IDLE;
					end
					idx_q <= idx_q + BW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						case (in_req.opcode)
							OP_MAP: begin
								if (in_req.region_length == '0) begin
									res_q   <= pack_res('0, ST_ZERO_LEN, '0, '0);
									state_q <= S_DONE;
								end else if (!paging_enabled) begin
									res_q   <= pack_res(64'(in_req.phys_addr), ST_OK, '0, '0);
									state_q <= S_DONE;
								end else begin
									res_q   <= '0;
									pa_q    <= 58'(in_req.phys_addr & ~PMASK);
									off_q   <= 64'(in_req.phys_addr) & OFF_MASK;
									len_q   <= in_req.region_length;
									attr_q  <= in_req.attributes;
									state_q <= S_PREP;
								end
							end
							OP_UNMAP: begin
								if (!paging_enabled) begin
									res_q   <= '0;
									state_q <= S_DONE;
								end else if (uslot >= 64'(TABLE_ENTRIES)) begin
									res_q   <= pack_res('0, ST_BAD_UNMAP, '0, '0);
									state_q <= S_DONE;
								end else begin
									res_q   <= '0;
									idx_q   <= BW'(uslot);
									first_q <= BW'(uslot);
									state_q <= S_URD;
								end
							end
							OP_LOAD: begin
								res_q   <= pack_res('0, ST_OK, in_req.entry_index,
									in_req.entry_index);
								state_q <= S_DONE;
							end
							default: begin
								res_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PREP: begin
					if (cnt_w >= 42'(TABLE_ENTRIES)) begin
						res_q.status <= ST_TOO_MANY;
						state_q      <= S_DONE;
					end else begin
						cnt_q    <= CW'(cnt_w);
						stride_q <= CW'(1);
						state_q  <= S_STRIDE;
					end
				end
				S_STRIDE: begin
					if (stride_q < cnt_q) begin
						stride_q <= stride_q << 1;
					end else begin
						base_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (32'(base_q) >= TABLE_ENTRIES) begin
						res_q.status <= ST_NO_RUN;
						state_q      <= S_DONE;
					end else if (32'(base_q) + 32'(cnt_q) > TABLE_ENTRIES) begin
						base_q <= base_q + BW'(stride_q);
					end else begin
						idx_q   <= base_q;
						end_q   <= base_q + BW'(cnt_q);
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (mem_rdata[ENTRY_VALID_BIT]) begin
						base_q  <= base_q + BW'(stride_q);
						state_q <= S_SCAN;
					end else if (last_wr) begin
						idx_q   <= base_q;
						state_q <= S_WR;
					end else begin
						idx_q   <= idx_q + BW'(1);
						state_q <= S_SRD;
					end
				end
				S_WR: begin
					pa_q  <= pa_q + PAGE_INC;
					idx_q <= idx_q + BW'(1);
					if (last_wr) begin
						res_q.result_addr <= TOP_BASE + ((64'(base_q) << PAGE_SHIFT) | off_q);
						res_q.first_entry <= 9'(base_q);
						res_q.last_entry  <= 9'(idx_q);
						state_q           <= S_DONE;
					end
				end
				S_URD: begin
					state_q <= S_UCHK;
				end
				S_UCHK: begin
					res_q.first_entry <= 9'(first_q);
					res_q.last_entry  <= 9'(idx_q);
					if (!mem_rdata[ENTRY_VALID_BIT]) begin
						res_q.status <= ST_BAD_UNMAP;
						state_q      <= S_DONE;
					end else if (mem_rdata[ENTRY_LAST_BIT]) begin
						state_q <= S_DONE;
					end else if (32'(idx_q) == TABLE_ENTRIES - 1) begin
						res_q.status <= ST_BAD_UNMAP;
						state_q      <= S_DONE;
					end else begin
						idx_q   <= idx_q + BW'(1);
						state_q <= S_URD;
					end
				end
				S_DONE: begin
					if (res_room) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`GMAP_ASSERT_IMP(a_wr_in_range, clk, arst_n, mem_we, 32'(mem_waddr) < TABLE_ENTRIES)
	`GMAP_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)
	`GMAP_ASSERT_NXT(a_res_to_idle, clk, arst_n, res_valid, state_q == S_IDLE)
endmodule

[src/gigapage_io_map_allocator.sv]
// ---------------------------------------------------------------------------
// gigapage io map allocator
// page table of large pages with run allocation, unmap walk and preload
// ---------------------------------------------------------------------------
// channel      | direction | content
// s_axis       | in        | map / unmap / load request, opcode in tuser
// m_axis       | out       | one result per request, status in tuser
// cfg          | in        | paging_enabled register write
//
// one request at a time: load, unused opcode and the cases answered at once
// go from acceptance through the result state back to idle
// map: set-up (entry count check, then stride doubling), then a scan over
// candidate runs, a read and then a check of each table entry examined, the
// writes of the run's entries and the hand-over of the result
// unmap walks the entries, reading each one and then checking and clearing it
// the registered read port of the table memory splits each examined entry into a read and a check
// after reset a clearing pass zeroes the table;
// no request is taken during it, cfg writes are taken as ever
// a finished result sits in the output register, so a new request is
// taken while m_axis is stalled
// ---------------------------------------------------------------------------
module gigapage_io_map_allocator #(
	parameter int unsigned TABLE_ENTRIES = 512,
	parameter int unsigned PAGE_SHIFT    = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  logic         cfg_wdata,      // paging_enabled
	// request stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// phys_addr, region_length, attributes, unmap_addr, entry_index, entry_value
	input  logic [295:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,   // opcode
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,   // result_addr, first_entry, last_entry, zero pad
	output logic [2:0]   m_axis_tuser    // status
);
	import gmap_pkg::*;

	logic    paging_q;
	logic    m_valid_q;
	res_t    m_res_q;
	in_req_t req;
	res_t    res;
	logic    res_valid;
	logic    res_room;

	// request unpacking, lowest field first
	assign req.opcode        = s_axis_tuser;
	assign req.phys_addr     = s_axis_tdata[55:0];
	assign req.region_length = s_axis_tdata[94:56];
	assign req.attributes    = s_axis_tdata[158:95];
	assign req.unmap_addr    = s_axis_tdata[222:159];
	assign req.entry_index   = s_axis_tdata[231:223];
	assign req.entry_value   = s_axis_tdata[295:232];

	// output register has room when empty or being drained
	assign res_room = !m_valid_q || m_axis_tready;

	gmap_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PAGE_SHIFT    (PAGE_SHIFT)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.paging_enabled (paging_q),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_req         (req),
		.res_room       (res_room),
		.res_valid      (res_valid),
		.res            (res)
	);

	// configuration register, translation on after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b1;
		end else if (cfg_we) begin
			paging_q <= cfg_wdata;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_res_q.last_entry, m_res_q.first_entry,
		m_res_q.result_addr};
	assign m_axis_tuser  = m_res_q.status;
endmodule

[sim/gigapage_io_map_allocator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gigapage io map allocator testbench
// drives map, unmap and load requests with random gaps and result stalls,
// predicts each result from a shadow page table and compares field by field
// ---------------------------------------------------------------------------
module gigapage_io_map_allocator_tb;
	import gmap_pkg::*;

	localparam int unsigned SLOTS     = 512;
	localparam int unsigned PG_SHIFT  = 30;
	localparam logic [1:0]  OP_NONE   = 2'd3;   // unused opcode, does nothing
	localparam int          IDLE_LIMIT = 6000;  // worst map search plus stalls and clear pass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [295:0] s_axis_tdata;   // phys_addr, region_length, attributes, unmap_addr,
	                              // entry_index, entry_value
	logic [1:0]   s_axis_tuser;   // opcode
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [87:0]  m_axis_tdata;   // result_addr, first_entry, last_entry, zero pad
	logic [2:0]   m_axis_tuser;   // status

	gigapage_io_map_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// shadow state
	logic [63:0] shadow_table [SLOTS];
	logic        shadow_paging;

	in_req_t     pending_reqs [$];   // requests not yet offered
	res_t        expected_res [$];   // results predicted, not yet seen
	logic [63:0] live_va [$];        // addresses of successful maps, for unmap
	in_req_t     cur_req;
	int          fail_cnt;
	bit          gaps_on;
	int          src_gap;
	int          sink_stall;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] slot_va(int unsigned slot, logic [63:0] off);
		return TOP_BASE + (64'(slot) << PG_SHIFT) + off;
	endfunction

	function automatic in_req_t make_req(logic [1:0] op, logic [55:0] pa, logic [38:0] len,
			logic [63:0] attr, logic [63:0] ua, logic [8:0] idx, logic [63:0] val);
		in_req_t r;
		r.opcode = op;
		r.phys_addr = pa;
		r.region_length = len;
		r.attributes = attr;
		r.unmap_addr = ua;
		r.entry_index = idx;
		r.entry_value = val;
		return r;
	endfunction

	// map: page round-down, power-of-two stride, first free aligned run
	function automatic res_t predict_map(in_req_t r);
		res_t        o;
		logic [63:0] pg_start, pg_off, npages, stride, pa;
		int          base;
		bit          run_free;
		o = '0;
		if (r.region_length == 0) begin
			o.status = ST_ZERO_LEN;
			return o;
		end
		if (!shadow_paging) begin
			o.result_addr = 64'(r.phys_addr);
			o.status = ST_OK;
			return o;
		end
		pg_start = 64'(r.phys_addr) & ~((64'd1 << PG_SHIFT) - 64'd1);
		pg_off = 64'(r.phys_addr) - pg_start;
		npages = (pg_off + 64'(r.region_length) + (64'd1 << PG_SHIFT) - 64'd1) >> PG_SHIFT;
		if (npages >= SLOTS) begin
			o.status = ST_TOO_MANY;
			return o;
		end
		stride = 1;
		while (stride < npages)
			stride = stride << 1;
		for (base = 0; base < SLOTS; base += int'(stride)) begin
			run_free = (64'(base) + npages <= SLOTS);
			for (int i = base; run_free && i < base + int'(npages); i++)
				if (shadow_table[i][ENTRY_VALID_BIT])
					run_free = 0;
			if (run_free) begin
				pa = pg_start;
				for (int i = base; i < base + int'(npages); i++) begin
					shadow_table[i] = (pa >> 2) | r.attributes;
					pa += 64'd1 << PG_SHIFT;
				end
				shadow_table[base + int'(npages) - 1][ENTRY_LAST_BIT] = 1'b1;
				o.result_addr = slot_va(base, pg_off);
				o.status = ST_OK;
				o.first_entry = 9'(base);
				o.last_entry = 9'(base + int'(npages) - 1);
				live_va.push_back(o.result_addr);
				return o;
			end
		end
		o.status = ST_NO_RUN;
		return o;
	endfunction

	// unmap: clear entries up to the last mark, stop on an invalid one
	function automatic res_t predict_unmap(in_req_t r);
		res_t        o;
		logic [63:0] first, e;
		o = '0;
		if (!shadow_paging)
			return o;
		first = (r.unmap_addr - TOP_BASE) >> PG_SHIFT;
		o.status = ST_BAD_UNMAP;
		if (first >= SLOTS)
			return o;
		o.first_entry = 9'(first);
		for (int i = int'(first); i < SLOTS; i++) begin
			e = shadow_table[i];
			o.last_entry = 9'(i);
			if (!e[ENTRY_VALID_BIT])
				return o;
			shadow_table[i] = '0;
			if (e[ENTRY_LAST_BIT]) begin
				o.status = ST_OK;
				return o;
			end
		end
		return o;
	endfunction

	function automatic res_t predict_result(in_req_t r);
		res_t o;
		o = '0;
		case (r.opcode)
			OP_MAP: o = predict_map(r);
			OP_UNMAP: o = predict_unmap(r);
			OP_LOAD: begin
				shadow_table[r.entry_index] = r.entry_value;
				o.first_entry = r.entry_index;
				o.last_entry = r.entry_index;
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	// random map length: mostly a few pages, sometimes up to 64, rarely any
	function automatic logic [38:0] rnd_length();
		int unsigned pick;
		logic [63:0] span;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 39'(rnd64());
		span = 64'($urandom_range(1, (pick < 3) ? 64 : 4)) << PG_SHIFT;
		return 39'((rnd64() % span) + 64'd1);
	endfunction

	function automatic in_req_t rnd_req();
		int unsigned pick, k;
		logic [63:0] attr, ua;
		pick = $urandom_range(0, 99);
		attr = rnd64();
		if ($urandom_range(0, 7) != 0)
			attr[ENTRY_VALID_BIT] = 1'b1;
		if ($urandom_range(0, 3) != 0)
			attr[ENTRY_LAST_BIT] = 1'b0;
		if (pick < 45)
			return make_req(OP_MAP, 56'(rnd64()), rnd_length(), attr, rnd64(), 9'($urandom),
				rnd64());
		if (pick < 85) begin
			if (live_va.size() > 0 && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, live_va.size() - 1);
				ua = live_va[k];
				live_va.delete(k);
			end else if ($urandom_range(0, 1) == 0)
				ua = slot_va($urandom_range(0, SLOTS - 1), 64'($urandom_range(0, 1023)));
			else
				ua = rnd64();
			return make_req(OP_UNMAP, 56'(rnd64()), 39'(rnd64()), rnd64(), ua, 9'($urandom),
				rnd64());
		end
		if (pick < 95)
			return make_req(OP_LOAD, 56'(rnd64()), 39'(rnd64()), rnd64(), rnd64(),
				9'($urandom), rnd64());
		return make_req(OP_NONE, 56'(rnd64()), 39'(rnd64()), rnd64(), rnd64(), 9'($urandom),
			rnd64());
	endfunction

	// request driver: predict on acceptance, then offer the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_res.push_back(predict_result(cur_req));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cur_req.opcode;
					s_axis_tdata <= {cur_req.entry_value, cur_req.entry_index,
						cur_req.unmap_addr, cur_req.attributes, cur_req.region_length,
						cur_req.phys_addr};
					if (gaps_on && $urandom_range(0, 9) == 0)
						src_gap <= $urandom_range(1, 19);
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.result_addr = m_axis_tdata[63:0];
				got.first_entry = m_axis_tdata[72:64];
				got.last_entry = m_axis_tdata[81:73];
				got.status = m_axis_tuser;
				if (expected_res.size() == 0) begin
					$display("%0t: result with none pending: addr %h status %0d", $time,
						got.result_addr, got.status);
					fail_cnt++;
				end else begin
					want = expected_res.pop_front();
					if (got.result_addr !== want.result_addr) begin
						$display("%0t: result_addr expected %h actual %h", $time,
							want.result_addr, got.result_addr);
						fail_cnt++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
						fail_cnt++;
					end
					if (got.first_entry !== want.first_entry) begin
						$display("%0t: first_entry expected %0d actual %0d", $time,
							want.first_entry, got.first_entry);
						fail_cnt++;
					end
					if (got.last_entry !== want.last_entry) begin
						$display("%0t: last_entry expected %0d actual %0d", $time,
							want.last_entry, got.last_entry);
						fail_cnt++;
					end
				end
			end
			if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (gaps_on && $urandom_range(0, 9) == 0)
					sink_stall <= $urandom_range(1, 19);
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("gigapage_io_map_allocator test failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_paging(logic on);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= on;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_paging = on;
	endtask

	// wait until every request is taken and every result seen
	task automatic drain();
		while (pending_reqs.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b1;
		fail_cnt = 0;
		gaps_on = 1;
		quiet_cycles = 0;
		shadow_paging = 1'b1;
		foreach (shadow_table[i])
			shadow_table[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_paging(1'b1);

		// directed: field extremes, every opcode and the corner cases
		pending_reqs.push_back(make_req(OP_MAP, 56'd0, 39'd0, 64'd1, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_MAP, 56'd0, 39'd1, 64'd1, 0, 0, 0));
		// crosses a page boundary, two pages
		pending_reqs.push_back(make_req(OP_MAP, 56'h3FFF_FFFF, 39'd2, 64'h3, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_MAP, '1, '1, '1, 0, 0, 0));
		// 511 pages fit only from slot 0, which is busy
		pending_reqs.push_back(make_req(OP_MAP, 56'd0, 39'(64'd511 << PG_SHIFT), 64'd1, 0, 0,
			0));
		// attributes without the valid bit leave the slot free
		pending_reqs.push_back(make_req(OP_MAP, 56'h40_0000_0000, 39'h4000_0000, 64'd0, 0, 0,
			0));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(0, 0), 0, 0));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(1, 0), 0, 0));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, 64'd0, 0, 0));
		pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 9'd511, 64'd1));
		// walk runs off the table end without a last mark
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(511, 64'h3FFF_FFFF), 0, 0));
		pending_reqs.push_back(make_req(OP_NONE, '1, '1, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(OP_LOAD, '1, '1, '1, '1, 9'd0, '1));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(2, 64'h3FFF_FFFF), 0, 0));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(0, 0), 0, 0));
		pending_reqs.push_back(make_req(OP_MAP, '1, 39'd1, '1, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_MAP, 0, 39'(64'd256 << PG_SHIFT), 64'd1, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_MAP, 0, 39'(64'd256 << PG_SHIFT), 64'd1, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(256, 0), 0, 0));
		drain();
		// pass-through with paging off
		write_paging(1'b0);
		pending_reqs.push_back(make_req(OP_MAP, '1, 39'd5, '1, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_MAP, '1, 39'd0, '1, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, slot_va(0, 0), 0, 0));
		pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 0, 9'd7, 64'h101));
		drain();
		write_paging(1'b1);

		// random chunks; paging off in some, no idling in the last ones
		for (int chunk = 0; chunk < 52; chunk++) begin
			if (chunk >= 46)
				gaps_on = 0;
			if (chunk % 7 == 3)
				write_paging(1'b0);
			for (int n = 0; n < 30; n++)
				pending_reqs.push_back(rnd_req());
			drain();
			if (!shadow_paging)
				write_paging(1'b1);
		end

		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("gigapage_io_map_allocator test passed");
		else
			$display("gigapage_io_map_allocator test failed");
		$finish;
	end
endmodule
